// ===== sv/bhpq_pkg.sv =====
// ============================================================================
// bhpq_pkg: shared types and helpers for the binary heap priority queue
// Sizes, channel words, links between level cells and the order compare.
// ============================================================================
package bhpq_pkg;

  // Store size and derived widths
  localparam int CAPACITY = 64;
  localparam int LVLS     = $clog2(CAPACITY + 1);  // heap levels, one cell each
  localparam int CNT_W    = LVLS;                  // holds 0..CAPACITY
  localparam int OFF_W    = LVLS - 1;              // offset within one level
  localparam int LVL_W    = (LVLS > 1) ? $clog2(LVLS) : 1;
  localparam int ROW      = 1 << OFF_W;            // entries per level cell
  localparam int LAST_LVL = LVLS - 1;
  localparam int ECNT_W   = 7;                     // reported entry count width

  // Opcodes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // Status codes
  localparam logic [1:0] STS_DONE  = 2'd0;
  localparam logic [1:0] STS_FULL  = 2'd1;
  localparam logic [1:0] STS_EMPTY = 2'd2;

  // Input word
  typedef struct packed {
    logic               opcode;
    logic signed [31:0] value;
  } in_t;

  // Result word
  typedef struct packed {
    logic signed [31:0] top_value;
    logic               is_empty;
    logic [ECNT_W-1:0]  entry_count;
    logic [1:0]         status;
  } out_t;

  // Work carried from cell to cell
  typedef enum logic [1:0] {
    TK_UP,
    TK_DN,
    TK_FETCH
  } tok_kind_t;

  typedef struct packed {
    logic               act;
    tok_kind_t          kind;
    logic [OFF_W-1:0]   off;
    logic signed [31:0] cur;
  } tok_t;

  // Entry write into a level cell
  typedef struct packed {
    logic               vld;
    logic [OFF_W-1:0]   off;
    logic signed [31:0] data;
  } wr_t;

  // Token injection from the controller
  typedef struct packed {
    logic [LVL_W-1:0] lvl;
    tok_t             tok;
  } start_t;

  // Cell report back to the controller
  typedef struct packed {
    logic               busy;
    logic               done;
    logic               fvld;
    logic signed [31:0] fdata;
  } rpt_t;

  // Heap position of an array index
  typedef struct packed {
    logic [LVL_W-1:0] lvl;
    logic [OFF_W-1:0] off;
  } pos_t;

  // True when a has to stay below b (mode 0: max first, mode 1: min first)
  function automatic logic loses(input logic signed [31:0] a,
                                 input logic signed [31:0] b,
                                 input logic               mode);
    return mode ? (a > b) : (a < b);
  endfunction

  // Level is the MSB of idx+1, offset is idx+1 with that bit cleared
  function automatic pos_t lvl_of(input logic [CNT_W-1:0] idx);
    logic [CNT_W-1:0] p1;
    logic [CNT_W-1:0] rem;
    pos_t             p;
    p1    = idx + CNT_W'(1);
    p.lvl = '0;
    for (int i = 0; i < CNT_W; i++) begin
      if (p1[i]) p.lvl = LVL_W'(i);
    end
    rem        = p1;
    rem[p.lvl] = 1'b0;
    p.off      = rem[OFF_W-1:0];
    return p;
  endfunction

endpackage

// ===== sv/binary_heap_priority_queue.sv =====
// ============================================================================
// binary_heap_priority_queue: heap priority queue of signed 32-bit values
// Controller plus a row of level cells that walk sift steps level by level.
// ============================================================================
// Usage:
//   in_valid/in_stall/in_data carry one word: opcode (push or pop) and value.
//   out_valid/out_stall/out_data return one word per input word: the root
//   after the operation (zero when empty), empty flag, entry count, status.
//   cfg_we/cfg_wdata set order_mode (0 largest first, 1 smallest first);
//   write it only while the queue is idle.
// Sequence:
//   Each sift step runs in one level cell: a registered read, then compare
//   and write. A push sifts up from the new entry's parent level toward the
//   root; a pop first fetches the last entry, then sifts it down level by
//   level from the root. Rejected and trivial operations skip both phases and
//   go straight to the result. One word is in flight at a time; in_stall is
//   high until the result has been moved into the output register, which may
//   still be waiting. The next word is taken in the cycle after the result is
//   loaded at the earliest.
// Reset: count and mode clear; stored entries are not cleared.
// A stalled output word holds; the next result waits until it is taken.
// ============================================================================
module binary_heap_priority_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  bhpq_pkg::in_t     in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output bhpq_pkg::out_t    out_data,
  input  logic              cfg_we,
  input  logic [0:0]        cfg_wdata
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_SIFT,
    ST_PUT
  } state_t;

  state_t                     state_r, state_nxt;
  logic [bhpq_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                       mode_r, mode_nxt;
  logic signed [31:0]         root_r, root_nxt;
  logic [1:0]                 sts_r, sts_nxt;
  logic                       out_valid_r, out_valid_nxt;
  bhpq_pkg::out_t             out_data_r, out_data_nxt;

  bhpq_pkg::start_t start;
  bhpq_pkg::wr_t    ext_wr;
  bhpq_pkg::pos_t   pos;
  logic [bhpq_pkg::CNT_W-1:0] cnt_dec;
  logic             accept;

  // Cell links
  bhpq_pkg::tok_t tok_up_w [bhpq_pkg::LVLS];
  bhpq_pkg::tok_t tok_dn_w [bhpq_pkg::LVLS];
  bhpq_pkg::wr_t  wr_up_w  [bhpq_pkg::LVLS];
  bhpq_pkg::wr_t  wr_dn_w  [bhpq_pkg::LVLS];
  bhpq_pkg::wr_t  wr_mon_w [bhpq_pkg::LVLS];
  bhpq_pkg::rpt_t rpt_w    [bhpq_pkg::LVLS];

  logic                       done_any, fvld_any;
  logic signed [31:0]         fdata_any;
  logic [bhpq_pkg::LVLS-1:0]  busy_v;

  // Level cells
  for (genvar k = 0; k < bhpq_pkg::LVLS; k++) begin : g_cell
    bhpq_pkg::tok_t t_from_up, t_from_dn;
    bhpq_pkg::wr_t  w_from_up, w_from_dn, w_ext;
    if (k == 0) begin : g_top_end
      assign t_from_up = '0;
      assign w_from_up = '0;
      assign w_ext     = ext_wr;
    end else begin : g_top_link
      assign t_from_up = tok_dn_w[k-1];
      assign w_from_up = wr_dn_w[k-1];
      assign w_ext     = '0;
    end
    if (k == bhpq_pkg::LVLS - 1) begin : g_bot_end
      assign t_from_dn = '0;
      assign w_from_dn = '0;
    end else begin : g_bot_link
      assign t_from_dn = tok_up_w[k+1];
      assign w_from_dn = wr_up_w[k+1];
    end
    bhpq_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .lvl_idx     (bhpq_pkg::LVL_W'(k)),
      .mode        (mode_r),
      .lim         (cnt_r),
      .start       (start),
      .tok_from_up (t_from_up),
      .tok_from_dn (t_from_dn),
      .wr_from_up  (w_from_up),
      .wr_from_dn  (w_from_dn),
      .wr_ext      (w_ext),
      .tok_to_up   (tok_up_w[k]),
      .tok_to_dn   (tok_dn_w[k]),
      .wr_to_up    (wr_up_w[k]),
      .wr_to_dn    (wr_dn_w[k]),
      .wr_mon      (wr_mon_w[k]),
      .rpt         (rpt_w[k])
    );
  end

  // Gather cell reports
  always_comb begin
    done_any  = 1'b0;
    fvld_any  = 1'b0;
    fdata_any = '0;
    for (int k = 0; k < bhpq_pkg::LVLS; k++) begin
      done_any  = done_any | rpt_w[k].done;
      fvld_any  = fvld_any | rpt_w[k].fvld;
      fdata_any = fdata_any | (rpt_w[k].fvld ? rpt_w[k].fdata : 32'sd0);
      busy_v[k] = rpt_w[k].busy;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign cnt_dec   = cnt_r - bhpq_pkg::CNT_W'(1);
  assign pos       = bhpq_pkg::lvl_of((in_data.opcode == bhpq_pkg::OP_PUSH) ? cnt_r : cnt_dec);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    mode_nxt      = mode_r;
    sts_nxt       = sts_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    root_nxt      = wr_mon_w[0].vld ? wr_mon_w[0].data : root_r;
    start         = '0;
    ext_wr        = '0;

    if (cfg_we) mode_nxt = cfg_wdata[0];

    // output word taken
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          sts_nxt   = bhpq_pkg::STS_DONE;
          state_nxt = ST_PUT;
          if (in_data.opcode == bhpq_pkg::OP_PUSH) begin
            if (cnt_r == bhpq_pkg::CNT_W'(bhpq_pkg::CAPACITY)) begin
              sts_nxt = bhpq_pkg::STS_FULL;
            end else begin
              cnt_nxt = cnt_r + bhpq_pkg::CNT_W'(1);
              if (pos.lvl == '0) begin
                ext_wr = '{vld: 1'b1, off: '0, data: in_data.value};
              end else begin
                start.lvl = pos.lvl - bhpq_pkg::LVL_W'(1);
                start.tok = '{act: 1'b1, kind: bhpq_pkg::TK_UP, off: pos.off,
                              cur: in_data.value};
                state_nxt = ST_SIFT;
              end
            end
          end else begin
            if (cnt_r == '0) begin
              sts_nxt = bhpq_pkg::STS_EMPTY;
            end else begin
              cnt_nxt = cnt_dec;
              if (cnt_dec != '0) begin
                start.lvl = pos.lvl;
                start.tok = '{act: 1'b1, kind: bhpq_pkg::TK_FETCH, off: pos.off,
                              cur: 32'sd0};
                state_nxt = ST_FETCH;
              end
            end
          end
        end
      end
      // last entry becomes the new root candidate
      ST_FETCH: begin
        if (fvld_any) begin
          start.lvl = bhpq_pkg::LVL_W'(1);
          start.tok = '{act: 1'b1, kind: bhpq_pkg::TK_DN, off: '0, cur: fdata_any};
          state_nxt = ST_SIFT;
        end
      end
      ST_SIFT: begin
        if (done_any) state_nxt = ST_PUT;
      end
      ST_PUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.top_value   = (cnt_r == '0) ? 32'sd0 : root_r;
          out_data_nxt.is_empty    = (cnt_r == '0);
          out_data_nxt.entry_count = bhpq_pkg::ECNT_W'(cnt_r);
          out_data_nxt.status      = sts_r;
          state_nxt                = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      mode_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      mode_r      <= mode_nxt;
      out_valid_r <= out_valid_nxt;
    end
    root_r     <= root_nxt;
    sts_r      <= sts_nxt;
    out_data_r <= out_data_nxt;
  end

  // Checks
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(busy_v))
    else $error("more than one level cell holds a token");

  a_done_in_sift: assert property (@(posedge clk) disable iff (!rst_n)
    done_any |-> state_r == ST_SIFT)
    else $error("sift finished outside sift phase");

  a_fetch_phase: assert property (@(posedge clk) disable iff (!rst_n)
    fvld_any |-> state_r == ST_FETCH)
    else $error("last-entry fetch returned outside fetch phase");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= bhpq_pkg::CNT_W'(bhpq_pkg::CAPACITY))
    else $error("entry count beyond capacity");

endmodule

// ===== sv/bhpq_cell.sv =====
// ============================================================================
// bhpq_cell: one heap level
// Holds its level's entries; with the token it runs a last-entry fetch or one
// sift step: read own entries, compare, write a neighbor level, pass the token.
// ============================================================================
module bhpq_cell (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [bhpq_pkg::LVL_W-1:0] lvl_idx,
  input  logic                  mode,
  input  logic [bhpq_pkg::CNT_W-1:0] lim,
  input  bhpq_pkg::start_t      start,
  input  bhpq_pkg::tok_t        tok_from_up,
  input  bhpq_pkg::tok_t        tok_from_dn,
  input  bhpq_pkg::wr_t         wr_from_up,
  input  bhpq_pkg::wr_t         wr_from_dn,
  input  bhpq_pkg::wr_t         wr_ext,
  output bhpq_pkg::tok_t        tok_to_up,
  output bhpq_pkg::tok_t        tok_to_dn,
  output bhpq_pkg::wr_t         wr_to_up,
  output bhpq_pkg::wr_t         wr_to_dn,
  output bhpq_pkg::wr_t         wr_mon,
  output bhpq_pkg::rpt_t        rpt
);

  bhpq_pkg::tok_t tok_r, tok_nxt;
  logic           ph_r, ph_nxt;       // 0: read issued, 1: compare

  logic signed [31:0] mem_r [bhpq_pkg::ROW];
  logic signed [31:0] q_a_r, q_b_r;

  logic [bhpq_pkg::OFF_W-1:0] ra, rb;
  logic [bhpq_pkg::OFF_W:0]   dbl;
  logic [bhpq_pkg::OFF_W-1:0] coff_l;
  logic [bhpq_pkg::OFF_W-1:0] poff;
  logic [bhpq_pkg::CNT_W:0]   lvl_bit, left_idx, right_idx;
  logic                       lv, rv;
  logic signed [31:0]         best;
  logic                       sel_l, sel_r;
  logic [bhpq_pkg::OFF_W-1:0] coff;
  logic                       is_last, is_root;
  bhpq_pkg::wr_t              wr_self, wr_sel;

  // Child and parent addressing
  always_comb begin
    dbl     = {tok_r.off, 1'b0};
    coff_l  = dbl[bhpq_pkg::OFF_W-1:0];
    poff    = tok_r.off >> 1;
    lvl_bit = (bhpq_pkg::CNT_W+1)'(1) << lvl_idx;
    left_idx  = lvl_bit - (bhpq_pkg::CNT_W+1)'(1) + (bhpq_pkg::CNT_W+1)'(coff_l);
    right_idx = left_idx + (bhpq_pkg::CNT_W+1)'(1);
    lv = left_idx  < {1'b0, lim};
    rv = right_idx < {1'b0, lim};
    is_last = (lvl_idx == bhpq_pkg::LVL_W'(bhpq_pkg::LAST_LVL));
    is_root = (lvl_idx == '0);
  end

  // Read address per token kind
  always_comb begin
    case (tok_r.kind)
      bhpq_pkg::TK_DN: ra = coff_l;
      bhpq_pkg::TK_UP: ra = poff;
      default:         ra = tok_r.off;
    endcase
    rb = ra | bhpq_pkg::OFF_W'(1);
  end

  // Compare step
  always_comb begin
    tok_to_up = '0;
    tok_to_dn = '0;
    wr_to_up  = '0;
    wr_to_dn  = '0;
    wr_self   = '0;
    rpt       = '0;
    rpt.busy  = tok_r.act;
    best      = tok_r.cur;
    sel_l     = 1'b0;
    sel_r     = 1'b0;
    coff      = coff_l;
    if (tok_r.act && ph_r) begin
      case (tok_r.kind)
        // sift down: children sit in this level, parent slot one level up
        bhpq_pkg::TK_DN: begin
          if (lv && bhpq_pkg::loses(best, q_a_r, mode)) begin
            best  = q_a_r;
            sel_l = 1'b1;
          end
          if (rv && bhpq_pkg::loses(best, q_b_r, mode)) begin
            best  = q_b_r;
            sel_l = 1'b0;
            sel_r = 1'b1;
          end
          if (sel_r) coff = rb;
          wr_to_up = '{vld: 1'b1, off: tok_r.off, data: best};
          if (!(sel_l || sel_r)) begin
            rpt.done = 1'b1;
          end else if (is_last) begin
            wr_self  = '{vld: 1'b1, off: coff, data: tok_r.cur};
            rpt.done = 1'b1;
          end else begin
            tok_to_dn = '{act: 1'b1, kind: bhpq_pkg::TK_DN, off: coff, cur: tok_r.cur};
          end
        end
        // sift up: parent sits in this level, child slot one level down
        bhpq_pkg::TK_UP: begin
          if (bhpq_pkg::loses(tok_r.cur, q_a_r, mode)) begin
            wr_to_dn = '{vld: 1'b1, off: tok_r.off, data: tok_r.cur};
            rpt.done = 1'b1;
          end else begin
            wr_to_dn = '{vld: 1'b1, off: tok_r.off, data: q_a_r};
            if (is_root) begin
              wr_self  = '{vld: 1'b1, off: '0, data: tok_r.cur};
              rpt.done = 1'b1;
            end else begin
              tok_to_up = '{act: 1'b1, kind: bhpq_pkg::TK_UP, off: poff, cur: tok_r.cur};
            end
          end
        end
        // last-entry fetch for a pop
        bhpq_pkg::TK_FETCH: begin
          rpt.fvld  = 1'b1;
          rpt.fdata = q_a_r;
        end
        default: ;
      endcase
    end
  end

  // Write select: only one source is active in a cycle
  always_comb begin
    if (wr_self.vld)         wr_sel = wr_self;
    else if (wr_from_up.vld) wr_sel = wr_from_up;
    else if (wr_from_dn.vld) wr_sel = wr_from_dn;
    else                     wr_sel = wr_ext;
  end
  assign wr_mon = wr_sel;

  // Token load / step
  always_comb begin
    tok_nxt = tok_r;
    ph_nxt  = ph_r;
    if (start.tok.act && start.lvl == lvl_idx) begin
      tok_nxt = start.tok;
      ph_nxt  = 1'b0;
    end else if (tok_from_up.act) begin
      tok_nxt = tok_from_up;
      ph_nxt  = 1'b0;
    end else if (tok_from_dn.act) begin
      tok_nxt = tok_from_dn;
      ph_nxt  = 1'b0;
    end else if (tok_r.act) begin
      if (ph_r) tok_nxt.act = 1'b0;
      ph_nxt = ~ph_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
      ph_r  <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
      ph_r  <= ph_nxt;
    end
  end

  // Level storage, registered reads
  always_ff @(posedge clk) begin
    if (wr_sel.vld) mem_r[wr_sel.off] <= wr_sel.data;
    q_a_r <= mem_r[ra];
    q_b_r <= mem_r[rb];
  end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb: self-checking bench for binary_heap_priority_queue
// Drives push and pop words with random gaps and output stalls, keeps its
// own heap to predict every result word, and compares each field in order.
// Covers both order modes, mode changes with entries stored, full and empty.
// ============================================================================
module tb;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int LONG_HOLD      = 300;
  localparam int PHASES         = 6;
  localparam int PHASE_WORDS    = 300;
  localparam int SETTLE_CYCLES  = 40;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  bhpq_pkg::in_t  in_data;
  logic out_valid;
  logic out_stall;
  bhpq_pkg::out_t out_data;
  logic cfg_we;
  logic [0:0] cfg_wdata;

  // Heap mirror used for prediction
  logic signed [31:0] pq_store [bhpq_pkg::CAPACITY];
  int                 pq_fill = 0;
  logic               pq_mode;

  bhpq_pkg::in_t  op_q[$];       // words waiting to be sent
  bhpq_pkg::out_t report_q[$];   // predicted result words, oldest first
  int   gen_fill;      // entry count as seen by the stimulus generator
  int   err_cnt = 0;
  int   results_seen;
  int   idle_cycles;

  // Sender and receiver pacing
  int gap_left;
  int send_calm;
  int stall_left;
  int recv_calm;
  int recv_roll;
  int long_holds;

  binary_heap_priority_queue uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // a has to sit below b in the current order
  function automatic logic ranks_below(input logic signed [31:0] a,
                                       input logic signed [31:0] b);
    return pq_mode ? (a > b) : (a < b);
  endfunction

  function automatic void swap_slots(input int i, input int j);
    logic signed [31:0] t;
    t           = pq_store[i];
    pq_store[i] = pq_store[j];
    pq_store[j] = t;
  endfunction

  // Apply one word to the heap mirror and return the expected result word
  function automatic bhpq_pkg::out_t heap_step(input bhpq_pkg::in_t w);
    bhpq_pkg::out_t r;
    int   pos;
    int   par;
    int   kid;
    int   best;
    logic walking;
    r        = '0;
    r.status = bhpq_pkg::STS_DONE;
    if (w.opcode == bhpq_pkg::OP_PUSH) begin
      if (pq_fill >= bhpq_pkg::CAPACITY) begin
        r.status = bhpq_pkg::STS_FULL;
      end else begin
        pos = pq_fill;
        pq_store[pos] = w.value;
        pq_fill++;
        // sift up; an entry equal to its parent still moves up
        walking = 1'b1;
        while (walking && pos > 0) begin
          par = (pos - 1) / 2;
          if (ranks_below(pq_store[pos], pq_store[par])) begin
            walking = 1'b0;
          end else begin
            swap_slots(pos, par);
            pos = par;
          end
        end
      end
    end else begin
      if (pq_fill == 0) begin
        r.status = bhpq_pkg::STS_EMPTY;
      end else begin
        pq_fill--;
        pq_store[0] = pq_store[pq_fill];
        // sift down; a child is taken only if it strictly wins, left first
        pos = 0;
        walking = 1'b1;
        while (walking) begin
          kid  = 2 * pos + 1;
          best = pos;
          if (kid < pq_fill) begin
            if (ranks_below(pq_store[best], pq_store[kid])) best = kid;
            if (kid + 1 < pq_fill && ranks_below(pq_store[best], pq_store[kid + 1]))
              best = kid + 1;
          end
          if (best == pos) begin
            walking = 1'b0;
          end else begin
            swap_slots(pos, best);
            pos = best;
          end
        end
      end
    end
    r.is_empty    = (pq_fill == 0);
    r.top_value   = (pq_fill > 0) ? pq_store[0] : '0;
    r.entry_count = bhpq_pkg::ECNT_W'(pq_fill);
    return r;
  endfunction

  task automatic note_error(input string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    err_cnt++;
  endtask

  // Gap length: mostly short, now and then long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  function automatic logic signed [31:0] pick_value();
    logic signed [31:0] v;
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      case ($urandom_range(0, 4))
        0: v = 32'sh7FFFFFFF;
        1: v = 32'sh80000000;
        2: v = 32'sd0;
        3: v = -32'sd1;
        default: v = 32'sd1;
      endcase
    end else if (r < 40) begin
      // narrow range so ties show up often
      v = $urandom_range(0, 16);
      v = v - 32'sd8;
    end else begin
      v = $urandom;
    end
    return v;
  endfunction

  task automatic queue_op(input logic op, input logic signed [31:0] v);
    bhpq_pkg::in_t w;
    w.opcode = op;
    w.value  = v;
    op_q.insert(op_q.size(), w);
    if (op == bhpq_pkg::OP_PUSH && gen_fill < bhpq_pkg::CAPACITY) gen_fill++;
    if (op == bhpq_pkg::OP_POP && gen_fill > 0) gen_fill--;
  endtask

  // One random sequence: fill to full, drain to empty, or a mixed run
  task automatic add_sequence(output int n);
    int r;
    int len;
    r = $urandom_range(0, 99);
    n = 0;
    if (r < 15) begin
      while (gen_fill < bhpq_pkg::CAPACITY) begin
        queue_op(bhpq_pkg::OP_PUSH, pick_value());
        n++;
      end
      len = $urandom_range(1, 3);
      repeat (len) queue_op(bhpq_pkg::OP_PUSH, pick_value());
      n += len;
    end else if (r < 30) begin
      while (gen_fill > 0) begin
        queue_op(bhpq_pkg::OP_POP, pick_value());
        n++;
      end
      len = $urandom_range(1, 3);
      repeat (len) queue_op(bhpq_pkg::OP_POP, pick_value());
      n += len;
    end else begin
      len = $urandom_range(10, 40);
      repeat (len) begin
        if ($urandom_range(0, 99) < 55) queue_op(bhpq_pkg::OP_PUSH, pick_value());
        else queue_op(bhpq_pkg::OP_POP, pick_value());
      end
      n += len;
    end
  endtask

  // Wait until every queued word is sent and every result is back;
  // sampled mid-cycle so the edge updates have settled
  task automatic wait_drained();
    while (op_q.size() != 0 || in_valid || report_q.size() != 0) @(negedge clk);
  endtask

  // Mode write; only called with the queue idle
  task automatic set_order(input logic m);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    pq_mode    = m;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Sender: holds a word until taken, then waits out a random gap
  always @(posedge clk) begin : send_p
    logic          nxt_valid;
    bhpq_pkg::in_t nxt_data;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      gap_left  = 0;
      send_calm = 0;
    end else begin
      nxt_valid = in_valid;
      nxt_data  = in_data;
      if (in_valid && !in_stall) begin
        report_q.insert(report_q.size(), heap_step(in_data));
        nxt_valid = 1'b0;
        if (send_calm > 0) begin
          send_calm--;
          gap_left = 0;
        end else if ($urandom_range(0, 99) < 4) begin
          send_calm = $urandom_range(20, 60);
          gap_left  = 0;
        end else begin
          gap_left = gap_len();
        end
      end
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (op_q.size() != 0) begin
          nxt_data  = op_q.pop_front();
          nxt_valid = 1'b1;
        end
      end
      in_valid <= nxt_valid;
      in_data  <= nxt_data;
    end
  end

  // Receiver stall: random stalls, quiet stretches, two long holds
  always @(posedge clk) begin : recv_p
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
      recv_calm  = 0;
      long_holds = 0;
    end else begin
      if (stall_left == 0) begin
        if (long_holds < 2 && results_seen >= 500 + 700 * long_holds) begin
          long_holds++;
          stall_left = LONG_HOLD;
        end else if (recv_calm > 0) begin
          recv_calm--;
        end else begin
          recv_roll = $urandom_range(0, 99);
          if (recv_roll < 3) recv_calm = $urandom_range(40, 150);
          else if (recv_roll < 28) stall_left = gap_len();
        end
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Monitor: compare each taken result word with the oldest prediction
  always @(posedge clk) begin : check_p
    bhpq_pkg::out_t want;
    if (!rst_n) begin
      results_seen <= 0;
    end else if (out_valid && !out_stall) begin
      results_seen <= results_seen + 1;
      if (report_q.size() == 0) begin
        note_error("result word with nothing expected");
      end else begin
        want = report_q.pop_front();
        if (out_data.top_value !== want.top_value)
          note_error($sformatf("top_value got %0d want %0d",
                               out_data.top_value, want.top_value));
        if (out_data.is_empty !== want.is_empty)
          note_error($sformatf("is_empty got %0b want %0b",
                               out_data.is_empty, want.is_empty));
        if (out_data.entry_count !== want.entry_count)
          note_error($sformatf("entry_count got %0d want %0d",
                               out_data.entry_count, want.entry_count));
        if (out_data.status !== want.status)
          note_error($sformatf("status got %0d want %0d",
                               out_data.status, want.status));
      end
    end
  end

  // Watchdog on cycles with no word moving on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stim_p
    int made;
    int n;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    pq_mode      = 1'b0;
    gen_fill     = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed, largest first: empty pop, extremes, duplicates, drain past empty
    set_order(1'b0);
    queue_op(bhpq_pkg::OP_POP, 32'sd0);
    queue_op(bhpq_pkg::OP_PUSH, 32'sd0);
    queue_op(bhpq_pkg::OP_PUSH, 32'sh7FFFFFFF);
    queue_op(bhpq_pkg::OP_PUSH, 32'sh80000000);
    queue_op(bhpq_pkg::OP_PUSH, -32'sd1);
    queue_op(bhpq_pkg::OP_PUSH, 32'sd1);
    queue_op(bhpq_pkg::OP_PUSH, 32'sd1);
    repeat (7) queue_op(bhpq_pkg::OP_POP, 32'sh7FFFFFFF);
    wait_drained();

    // Directed, smallest first; two entries stay across the next mode change
    set_order(1'b1);
    queue_op(bhpq_pkg::OP_PUSH, -32'sd5);
    queue_op(bhpq_pkg::OP_PUSH, 32'sh80000000);
    queue_op(bhpq_pkg::OP_PUSH, 32'sh7FFFFFFF);
    queue_op(bhpq_pkg::OP_PUSH, -32'sd5);
    queue_op(bhpq_pkg::OP_POP, 32'sd0);
    queue_op(bhpq_pkg::OP_POP, 32'sd0);
    wait_drained();

    // Random phases, alternating order, heap contents kept across changes
    for (int ph = 0; ph < PHASES; ph++) begin
      set_order(1'(ph % 2));
      made = 0;
      while (made < PHASE_WORDS) begin
        add_sequence(n);
        made += n;
      end
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
